// ===== design/fbe_pkg.sv =====
`default_nettype none

package fbe_pkg;

    // Field widths of the command and result beats.
    localparam int REQ_W    = 3;
    localparam int COORD_W  = 12;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 4 * CHAN_W;

    // Screen size registers are nine bits wide, so every clipped coordinate fits in this.
    localparam int SIZE_W   = 9;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RGB_ONLY      = 2'd2;

    // Default store geometry.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MEM_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int DEF_ADDR_W     = $clog2(DEF_MEM_DEPTH);

    // Command codes.
    localparam logic [REQ_W-1:0] REQ_READ         = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_OPAQUE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE_BLEND  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FILL_OPAQUE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FILL_BLEND   = 3'd4;

    // Per-pixel operation kinds.
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_OPAQUE = 2'd1;
    localparam logic [1:0] OP_BLEND  = 2'd2;

    // Byte lanes of a stored pixel word.
    localparam int RED_LSB   = 0;
    localparam int GREEN_LSB = 8;
    localparam int BLUE_LSB  = 16;
    localparam int ALPHA_LSB = 24;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] rect_w;
        logic [COORD_W-1:0] rect_h;
        logic [CHAN_W-1:0]  src_red;
        logic [CHAN_W-1:0]  src_green;
        logic [CHAN_W-1:0]  src_blue;
        logic [CHAN_W-1:0]  src_alpha;
    } t_req_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              read_hit;
    } t_rsp_beat;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_pix_cmd;

    typedef struct packed {
        logic     valid;
        logic     last;
        t_pix_cmd cmd;
    } t_pix_op;

    typedef struct packed {
        logic      busy;
        logic      done;
        t_rsp_beat rsp;
    } t_rmw_status;

    // (s*a + d*(255-a)) >> 8; the sum never exceeds 255*255.
    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] s,
                                                     input logic [CHAN_W-1:0] d);
        logic [2*CHAN_W-1:0] p_src;
        logic [2*CHAN_W-1:0] p_dst;
        logic [2*CHAN_W:0]   acc;
        p_src = (2*CHAN_W)'(s * a);
        p_dst = (2*CHAN_W)'(d * (CHAN_MAX - a));
        acc   = {1'b0, p_src} + {1'b0, p_dst};
        return acc[CHAN_W +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/fbe_walker.sv =====
`default_nettype none

module fbe_walker #(
    parameter int ADDR_W = fbe_pkg::DEF_ADDR_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  fbe_pkg::t_req_beat        i_req,
    input  logic [fbe_pkg::SIZE_W-1:0] i_act_w,
    input  logic [fbe_pkg::SIZE_W-1:0] i_act_h,
    output fbe_pkg::t_pix_op          o_iss,
    output logic [ADDR_W-1:0]         o_iss_addr,
    output logic                      o_busy,
    output logic                      o_nodraw
);
    import fbe_pkg::*;

    localparam int EW = COORD_W + 1;
    localparam int PW = 2 * SIZE_W + 1;

    logic                r_busy;
    logic [SIZE_W-1:0]   r_x;
    logic [SIZE_W-1:0]   r_y;
    logic [SIZE_W-1:0]   r_x0;
    logic [SIZE_W-1:0]   r_xe;
    logic [SIZE_W-1:0]   r_ye;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_row_addr;
    t_pix_cmd            r_cmd;

    logic                n_busy;
    logic [SIZE_W-1:0]   n_x;
    logic [SIZE_W-1:0]   n_y;
    logic [ADDR_W-1:0]   n_addr;
    logic [ADDR_W-1:0]   n_row_addr;

    logic                is_fill;
    logic                type_ok;
    logic [COORD_W-1:0]  span_w;
    logic [COORD_W-1:0]  span_h;
    logic [EW-1:0]       xe_raw;
    logic [EW-1:0]       ye_raw;
    logic [SIZE_W-1:0]   st_xe;
    logic [SIZE_W-1:0]   st_ye;
    logic                st_draw;
    logic [PW-1:0]       st_addr_full;
    t_pix_cmd            st_cmd;

    logic                cur_valid;
    logic [SIZE_W-1:0]   cur_x;
    logic [SIZE_W-1:0]   cur_y;
    logic [SIZE_W-1:0]   cur_x0;
    logic [SIZE_W-1:0]   cur_xe;
    logic [SIZE_W-1:0]   cur_ye;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   cur_row;
    t_pix_cmd            cur_cmd;
    logic                x_more;
    logic                y_more;

    // Decode and clip the incoming command. Single-pixel commands are 1x1 rectangles.
    always_comb begin
        is_fill = i_req.req_type inside {REQ_FILL_OPAQUE, REQ_FILL_BLEND};
        type_ok = 1'b1;
        st_cmd.kind  = OP_READ;
        st_cmd.red   = i_req.src_red;
        st_cmd.green = i_req.src_green;
        st_cmd.blue  = i_req.src_blue;
        st_cmd.alpha = i_req.src_alpha;
        case (i_req.req_type)
            REQ_READ: begin
                st_cmd.kind = OP_READ;
            end
            REQ_WRITE_OPAQUE, REQ_FILL_OPAQUE: begin
                st_cmd.kind = OP_OPAQUE;
            end
            REQ_WRITE_BLEND, REQ_FILL_BLEND: begin
                st_cmd.kind = OP_BLEND;
            end
            default: begin
                type_ok = 1'b0;
            end
        endcase

        span_w = is_fill ? i_req.rect_w : COORD_W'(1);
        span_h = is_fill ? i_req.rect_h : COORD_W'(1);
        xe_raw = {1'b0, i_req.pos_x} + {1'b0, span_w};
        ye_raw = {1'b0, i_req.pos_y} + {1'b0, span_h};
        st_xe  = (xe_raw > EW'(i_act_w)) ? i_act_w : xe_raw[SIZE_W-1:0];
        st_ye  = (ye_raw > EW'(i_act_h)) ? i_act_h : ye_raw[SIZE_W-1:0];

        st_draw = type_ok && (EW'(i_req.pos_x) < EW'(st_xe))
                          && (EW'(i_req.pos_y) < EW'(st_ye));

        // Only meaningful when something is drawn; then both coordinates fit in SIZE_W.
        st_addr_full = PW'(i_req.pos_y[SIZE_W-1:0] * i_act_w)
                     + PW'(i_req.pos_x[SIZE_W-1:0]);
    end

    // The first pixel of a command goes out in its accept cycle, the rest from registers.
    always_comb begin
        if (r_busy) begin
            cur_x   = r_x;
            cur_y   = r_y;
            cur_x0  = r_x0;
            cur_xe  = r_xe;
            cur_ye  = r_ye;
            cur_addr = r_addr;
            cur_row = r_row_addr;
            cur_cmd = r_cmd;
        end else begin
            cur_x   = i_req.pos_x[SIZE_W-1:0];
            cur_y   = i_req.pos_y[SIZE_W-1:0];
            cur_x0  = i_req.pos_x[SIZE_W-1:0];
            cur_xe  = st_xe;
            cur_ye  = st_ye;
            cur_addr = ADDR_W'(st_addr_full);
            cur_row = ADDR_W'(st_addr_full);
            cur_cmd = st_cmd;
        end
        cur_valid = r_busy || (i_start && st_draw);

        x_more = ({1'b0, cur_x} + (SIZE_W + 1)'(1)) < {1'b0, cur_xe};
        y_more = ({1'b0, cur_y} + (SIZE_W + 1)'(1)) < {1'b0, cur_ye};

        n_busy = cur_valid && (x_more || y_more);
        if (x_more) begin
            n_x        = cur_x + SIZE_W'(1);
            n_y        = cur_y;
            n_addr     = cur_addr + ADDR_W'(1);
            n_row_addr = cur_row;
        end else begin
            n_x        = cur_x0;
            n_y        = cur_y + SIZE_W'(1);
            n_addr     = cur_row + ADDR_W'(i_act_w);
            n_row_addr = cur_row + ADDR_W'(i_act_w);
        end

        o_iss.valid = cur_valid;
        o_iss.last  = !x_more && !y_more;
        o_iss.cmd   = cur_cmd;
        o_iss_addr  = cur_addr;
        o_busy      = r_busy;
        o_nodraw    = i_start && !st_draw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cur_valid) begin
            r_x        <= n_x;
            r_y        <= n_y;
            r_x0       <= cur_x0;
            r_xe       <= cur_xe;
            r_ye       <= cur_ye;
            r_addr     <= n_addr;
            r_row_addr <= n_row_addr;
            r_cmd      <= cur_cmd;
        end
    end

    a_walk_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_x < r_xe) && (r_y < r_ye))
        else $error("walker position left the clipped rectangle");

endmodule

`default_nettype wire

// ===== design/fbe_rmw.sv =====
`default_nettype none

module fbe_rmw #(
    parameter int ADDR_W    = fbe_pkg::DEF_ADDR_W,
    parameter int MEM_DEPTH = fbe_pkg::DEF_MEM_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fbe_pkg::t_pix_op    i_iss,
    input  logic [ADDR_W-1:0]   i_iss_addr,
    input  logic                i_rgb_only,
    output fbe_pkg::t_rmw_status o_status
);
    import fbe_pkg::*;

    logic [PIX_W-1:0]  r_mem [MEM_DEPTH];
    logic [PIX_W-1:0]  r_rd_data;

    logic              r_b_valid;
    logic              r_b_last;
    t_pix_cmd          r_b_cmd;
    logic [ADDR_W-1:0] r_b_addr;

    logic              rd_en;
    logic              wr_en;
    logic              full_write;
    logic [PIX_W-1:0]  wr_data;

    // Opaque pixels never look at the old value, so they skip the read.
    assign rd_en = i_iss.valid && (i_iss.cmd.kind != OP_OPAQUE);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[i_iss_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_b_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_iss.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_iss.valid) begin
            r_b_last <= i_iss.last;
            r_b_cmd  <= i_iss.cmd;
            r_b_addr <= i_iss_addr;
        end
    end

    always_comb begin
        full_write = (r_b_cmd.kind == OP_OPAQUE) || (r_b_cmd.alpha == CHAN_MAX);
        wr_en = r_b_valid && ((r_b_cmd.kind == OP_OPAQUE) ||
                              ((r_b_cmd.kind == OP_BLEND) && (r_b_cmd.alpha != '0)));
        if (full_write) begin
            wr_data = {(i_rgb_only ? CHAN_W'(0) : r_b_cmd.alpha),
                       r_b_cmd.blue, r_b_cmd.green, r_b_cmd.red};
        end else begin
            wr_data = {CHAN_W'(0),
                       blend_chan(r_b_cmd.alpha, r_b_cmd.blue,  r_rd_data[BLUE_LSB  +: CHAN_W]),
                       blend_chan(r_b_cmd.alpha, r_b_cmd.green, r_rd_data[GREEN_LSB +: CHAN_W]),
                       blend_chan(r_b_cmd.alpha, r_b_cmd.red,   r_rd_data[RED_LSB   +: CHAN_W])};
        end

        o_status.busy = r_b_valid;
        o_status.done = r_b_valid && r_b_last;
        o_status.rsp  = '0;
        if (r_b_cmd.kind == OP_READ) begin
            o_status.rsp.out_red   = r_rd_data[RED_LSB   +: CHAN_W];
            o_status.rsp.out_green = r_rd_data[GREEN_LSB +: CHAN_W];
            o_status.rsp.out_blue  = r_rd_data[BLUE_LSB  +: CHAN_W];
            o_status.rsp.out_alpha = i_rgb_only ? CHAN_MAX : r_rd_data[ALPHA_LSB +: CHAN_W];
            o_status.rsp.read_hit  = 1'b1;
        end
    end

    // A new command is only taken once this stage has drained, so the next
    // read can never meet a write to the same pixel in flight.
    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_last) |=> !r_b_valid)
        else $error("pixel stage busy right after the last pixel of a command");

endmodule

`default_nettype wire

// ===== design/framebuffer_blend_fill_engine_unit.sv =====
`default_nettype none

// Framebuffer drawing engine: reads, writes, blends and fills pixels of a
// screen held in an on-chip store addressed as y * width + x.
// Command channel: i_req_valid / o_req_stall carry one command beat; it is
// taken at a clock edge with valid high and stall low. Result channel:
// o_rsp_valid / i_rsp_stall return exactly one result beat per command, in
// order. Only reads return pixel data; every other command answers zeros.
// A command that touches N clipped pixels issues one pixel per cycle starting
// in its accept cycle; its last pixel passes the pixel store read and the blend
// stage register, then the result register, before its result beat is valid.
// The next command is taken only once the pixel store read and the blend stage
// behind it, which must drain before the next command may read, are empty and
// the result register is free, at the earliest at the edge where that result
// beat is taken. A command drawing nothing answers right after its accept edge.
// While the result beat is stalled it is held unchanged and no new command is
// taken. Configuration writes on i_cfg_we land at once; issue them only while
// the engine is idle. Reset clears the screen size and mode registers and the
// control state; the pixel store itself is not cleared and holds nothing
// meaningful until drawn.

module framebuffer_blend_fill_engine_unit #(
    parameter int MAX_WIDTH  = fbe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbe_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_req_valid,
    output logic                           o_req_stall,
    input  fbe_pkg::t_req_beat             i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_stall,
    output fbe_pkg::t_rsp_beat             o_rsp
);
    import fbe_pkg::*;

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Configuration registers.
    logic [SIZE_W-1:0] r_scr_w;
    logic [SIZE_W-1:0] r_scr_h;
    logic              r_rgb_only;

    // Result beat register.
    logic              r_rsp_valid;
    t_rsp_beat         r_rsp;
    logic              n_rsp_valid;
    t_rsp_beat         n_rsp;

    logic [SIZE_W-1:0] act_w;
    logic [SIZE_W-1:0] act_h;
    logic              idle;
    logic              out_free;
    logic              accept;

    t_pix_op           iss;
    logic [ADDR_W-1:0] iss_addr;
    logic              walk_busy;
    logic              nodraw;
    t_rmw_status       status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w    <= '0;
            r_scr_h    <= '0;
            r_rgb_only <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCREEN_WIDTH: begin
                    r_scr_w <= i_cfg_wdata;
                end
                CFG_SCREEN_HEIGHT: begin
                    r_scr_h <= i_cfg_wdata;
                end
                CFG_RGB_ONLY: begin
                    r_rgb_only <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Screen size as programmed, saturated to the size of the store.
    assign act_w = (int'(r_scr_w) > MAX_WIDTH)  ? SIZE_W'(MAX_WIDTH)  : r_scr_w;
    assign act_h = (int'(r_scr_h) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_scr_h;

    // One command at a time: take a new one only when the walker and the
    // blend stage are both empty and the result register is free this edge.
    assign idle        = !walk_busy && !status.busy;
    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_req_stall = !(idle && out_free);
    assign accept      = i_req_valid && !o_req_stall;

    fbe_walker #(
        .ADDR_W (ADDR_W)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_req      (i_req),
        .i_act_w    (act_w),
        .i_act_h    (act_h),
        .o_iss      (iss),
        .o_iss_addr (iss_addr),
        .o_busy     (walk_busy),
        .o_nodraw   (nodraw)
    );

    fbe_rmw #(
        .ADDR_W    (ADDR_W),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_rmw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_iss      (iss),
        .i_iss_addr (iss_addr),
        .i_rgb_only (r_rgb_only),
        .o_status   (status)
    );

    // A command either finishes through the pixel stage (its last pixel) or,
    // when nothing is drawn at all, answers zeros right at accept.
    always_comb begin
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_rsp       = r_rsp;
        if (status.done) begin
            n_rsp_valid = 1'b1;
            n_rsp       = status.rsp;
        end else if (nodraw) begin
            n_rsp_valid = 1'b1;
            n_rsp       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.done || nodraw) |-> !(r_rsp_valid && i_rsp_stall))
        else $error("new result while a stalled result beat is still held");

    a_single_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.done && nodraw))
        else $error("two commands finished in the same cycle");

    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.done) |-> !iss.valid)
        else $error("pixel issued while the previous command was finishing");

endmodule

`default_nettype wire

// ===== tb/tb_framebuffer_blend_fill_engine_unit.sv =====
`default_nettype none

module tb_framebuffer_blend_fill_engine_unit;
    import fbe_pkg::*;

    localparam int SCREEN_MAX_W = DEF_MAX_WIDTH;
    localparam int SCREEN_MAX_H = DEF_MAX_HEIGHT;
    localparam int MEM_DEPTH    = DEF_MEM_DEPTH;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;

    // Command codes the engine does not know; it must answer them with zeros.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

    // The configuration index has one value past the register list; the engine ignores it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // Fills larger than this are pushed toward the bottom edge so that they stay cheap,
    // except for at most two over the whole run that keep their full clipped area.
    localparam int FILL_AREA_CAP = 1024;

    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 110;

    // Screen settings of the random phases: widths and heights past the store size
    // saturate, and a zero in either one leaves nothing on screen.
    int phase_width  [PHASES] = '{256, 16, 511, 0, 1, 37, 256, 200, 64};
    int phase_height [PHASES] = '{256, 12, 511, 40, 1, 23, 256, 0, 48};
    int phase_rgb    [PHASES] = '{0, 1, 0, 0, 1, 0, 1, 0, 1};

    // Expected-result tracker: keeps its own copy of the pixel store and the screen
    // registers, predicts one result beat per accepted command and matches result
    // beats against those predictions in order.
    class fb_scoreboard;
        logic [PIX_W-1:0] pixel_mem [MEM_DEPTH];
        int unsigned      scr_w;
        int unsigned      scr_h;
        bit               rgb_only;
        t_rsp_beat        expected_results [$];
        int unsigned      error_count;
        int unsigned      read_hits;

        function void set_screen(int unsigned w, int unsigned h, bit rgb);
            scr_w    = (w > SCREEN_MAX_W) ? SCREEN_MAX_W : w;
            scr_h    = (h > SCREEN_MAX_H) ? SCREEN_MAX_H : h;
            rgb_only = rgb;
        endfunction

        function bit on_screen(int unsigned x, int unsigned y);
            return x < scr_w && y < scr_h;
        endfunction

        function int unsigned pixel_addr(int unsigned x, int unsigned y);
            return (y * scr_w + x) % MEM_DEPTH;
        endfunction

        function logic [CHAN_W-1:0] mix(int unsigned a, int unsigned s, int unsigned d);
            return CHAN_W'((s * a + d * (CHAN_MAX - a)) >> 8);
        endfunction

        function void draw_pixel(int unsigned x, int unsigned y, t_req_beat c, bit blend);
            logic [PIX_W-1:0] old_word;
            logic [PIX_W-1:0] new_word;
            if (!on_screen(x, y)) return;
            if (blend && c.src_alpha == 0) return;
            if (!blend || c.src_alpha == CHAN_MAX) begin
                new_word = {rgb_only ? 8'h00 : c.src_alpha, c.src_blue, c.src_green,
                            c.src_red};
            end else begin
                // A partial blend always leaves a zero alpha byte behind.
                old_word = pixel_mem[pixel_addr(x, y)];
                new_word = {8'h00,
                            mix(c.src_alpha, c.src_blue, old_word[BLUE_LSB +: CHAN_W]),
                            mix(c.src_alpha, c.src_green, old_word[GREEN_LSB +: CHAN_W]),
                            mix(c.src_alpha, c.src_red, old_word[RED_LSB +: CHAN_W])};
            end
            pixel_mem[pixel_addr(x, y)] = new_word;
        endfunction

        function void note_command(t_req_beat c);
            t_rsp_beat        res;
            logic [PIX_W-1:0] word;
            int unsigned      x_end;
            int unsigned      y_end;
            res = '0;
            case (c.req_type)
                REQ_READ: begin
                    if (on_screen(c.pos_x, c.pos_y)) begin
                        word          = pixel_mem[pixel_addr(c.pos_x, c.pos_y)];
                        res.out_red   = word[RED_LSB +: CHAN_W];
                        res.out_green = word[GREEN_LSB +: CHAN_W];
                        res.out_blue  = word[BLUE_LSB +: CHAN_W];
                        res.out_alpha = rgb_only ? CHAN_MAX : word[ALPHA_LSB +: CHAN_W];
                        res.read_hit  = 1'b1;
                        read_hits++;
                    end
                end
                REQ_WRITE_OPAQUE: draw_pixel(c.pos_x, c.pos_y, c, 1'b0);
                REQ_WRITE_BLEND:  draw_pixel(c.pos_x, c.pos_y, c, 1'b1);
                REQ_FILL_OPAQUE, REQ_FILL_BLEND: begin
                    x_end = c.pos_x + c.rect_w;
                    y_end = c.pos_y + c.rect_h;
                    if (x_end > scr_w) x_end = scr_w;
                    if (y_end > scr_h) y_end = scr_h;
                    for (int unsigned y = c.pos_y; y < y_end; y++) begin
                        for (int unsigned x = c.pos_x; x < x_end; x++) begin
                            draw_pixel(x, y, c, c.req_type == REQ_FILL_BLEND);
                        end
                    end
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [CHAN_W-1:0] want,
                                    logic [CHAN_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_rsp_beat got);
            t_rsp_beat want;
            if (expected_results.size() == 0) begin
                $error("result beat arrived with no command outstanding");
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("out_red", want.out_red, got.out_red);
            compare_field("out_green", want.out_green, got.out_green);
            compare_field("out_blue", want.out_blue, got.out_blue);
            compare_field("out_alpha", want.out_alpha, got.out_alpha);
            compare_field("read_hit", CHAN_W'(want.read_hit), CHAN_W'(got.read_hit));
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    t_req_beat             req_beat  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    t_rsp_beat             rsp_beat;

    fb_scoreboard sb;

    // Idle odds in percent for the command sender and the result receiver, and the
    // length of a deliberate hold-off on the result side.
    int unsigned send_idle_pct   = 0;
    int unsigned rcv_idle_pct    = 0;
    int unsigned rsp_hold_cycles = 0;

    // Random-stimulus bookkeeping.
    int unsigned large_fills_left = 2;
    int unsigned last_x = 0;
    int unsigned last_y = 0;

    // Tallies for the closing summary.
    int unsigned n_reads   = 0;
    int unsigned n_writes  = 0;
    int unsigned n_fills   = 0;
    int unsigned n_unknown = 0;

    framebuffer_blend_fill_engine_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_beat),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp_beat)
    );

    always #6 clk = ~clk;

    // Writes all three screen registers on back-to-back edges, then pokes the unused
    // index with junk, which the engine must ignore. The write enable stays high for
    // the whole burst so it is never dropped and raised within one step.
    task automatic apply_screen_config(int unsigned w, int unsigned h, bit rgb);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_SCREEN_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_idx   <= CFG_SCREEN_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_idx   <= CFG_RGB_ONLY;
        cfg_wdata <= CFG_DATA_W'(rgb);
        @(posedge clk);
        cfg_idx   <= CFG_UNUSED_IDX;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_screen(w, h, rgb);
    endtask

    // Offers one command beat and holds it until the engine takes it. After the
    // beat is taken the sender may go quiet for a random number of cycles; if it
    // does not, valid simply stays high into the next beat.
    task automatic send_command(t_req_beat c);
        req_valid <= 1'b1;
        req_beat  <= c;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_command(c);
        case (c.req_type)
            REQ_READ:                          n_reads++;
            REQ_WRITE_OPAQUE, REQ_WRITE_BLEND: n_writes++;
            REQ_FILL_OPAQUE, REQ_FILL_BLEND:   n_fills++;
            default:                           n_unknown++;
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering commands and waits until every predicted result has come
    // back. Each command answers exactly once, so by then the engine has settled
    // and its registers may be touched.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic t_req_beat make_cmd(logic [REQ_W-1:0] op, int unsigned x,
                                           int unsigned y, int unsigned w,
                                           int unsigned h, logic [CHAN_W-1:0] r,
                                           logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                                           logic [CHAN_W-1:0] a);
        t_req_beat c;
        c.req_type  = op;
        c.pos_x     = COORD_W'(x);
        c.pos_y     = COORD_W'(y);
        c.rect_w    = COORD_W'(w);
        c.rect_h    = COORD_W'(h);
        c.src_red   = r;
        c.src_green = g;
        c.src_blue  = b;
        c.src_alpha = a;
        return c;
    endfunction

    // Mostly on-screen coordinates, with the rest anywhere in the 12-bit range so
    // that clipping and the high coordinate bits are exercised.
    function automatic int unsigned pick_coord(int unsigned limit);
        if (limit > 0 && $urandom_range(99) < 75) return $urandom_range(limit - 1);
        return $urandom_range(COORD_MAX);
    endfunction

    // Rectangle sides are usually tiny, sometimes up to the screen size and now and
    // then anywhere in the field's range.
    function automatic int unsigned pick_extent(int unsigned limit);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70) return $urandom_range(6);
        if (sel < 85) return $urandom_range(limit);
        return $urandom_range(COORD_MAX);
    endfunction

    function automatic t_req_beat random_command();
        t_req_beat   c;
        int unsigned sel;
        int unsigned x_end;
        int unsigned y_end;
        int unsigned area;
        c = t_req_beat'({$urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(99);
        if (sel < 30)      c.req_type = REQ_READ;
        else if (sel < 50) c.req_type = REQ_WRITE_OPAQUE;
        else if (sel < 70) c.req_type = REQ_WRITE_BLEND;
        else if (sel < 82) c.req_type = REQ_FILL_OPAQUE;
        else if (sel < 94) c.req_type = REQ_FILL_BLEND;
        else c.req_type = REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));

        c.pos_x  = COORD_W'(pick_coord(sb.scr_w));
        c.pos_y  = COORD_W'(pick_coord(sb.scr_h));
        c.rect_w = COORD_W'(pick_extent(sb.scr_w));
        c.rect_h = COORD_W'(pick_extent(sb.scr_h));

        // Opaque and fully transparent alpha get a good share of the blends.
        sel = $urandom_range(99);
        if (sel < 20)      c.src_alpha = '0;
        else if (sel < 40) c.src_alpha = CHAN_MAX;

        if (c.req_type == REQ_READ && $urandom_range(99) < 40) begin
            // Look back at the last spot that was drawn so writes get observed.
            c.pos_x = COORD_W'(last_x);
            c.pos_y = COORD_W'(last_y);
        end

        if (c.req_type == REQ_FILL_OPAQUE || c.req_type == REQ_FILL_BLEND) begin
            x_end = c.pos_x + c.rect_w;
            y_end = c.pos_y + c.rect_h;
            if (x_end > sb.scr_w) x_end = sb.scr_w;
            if (y_end > sb.scr_h) y_end = sb.scr_h;
            area = (x_end > c.pos_x ? x_end - c.pos_x : 0) *
                   (y_end > c.pos_y ? y_end - c.pos_y : 0);
            if (area > FILL_AREA_CAP) begin
                if (large_fills_left > 0 && $urandom_range(3) == 0) begin
                    large_fills_left--;
                end else begin
                    // Keep the wide rectangle but let only its last few rows land.
                    c.pos_y = COORD_W'(sb.scr_h - $urandom_range(1, 4));
                end
            end
        end

        if (c.req_type != REQ_READ) begin
            last_x = c.pos_x;
            last_y = c.pos_y;
        end
        return c;
    endfunction

    // Directed opening on a full 256x256 screen. The first fill paints every store
    // entry, so no later read or blend can touch a pixel that was never written.
    task automatic run_directed();
        send_command(make_cmd(REQ_FILL_OPAQUE, 0, 0, COORD_MAX, COORD_MAX,
                              8'h11, 8'h22, 8'h33, 8'h44));
        // Corners of the screen, just past its edge and the far end of the range.
        send_command(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_READ, 255, 255, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_READ, 256, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_READ, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0, 0));
        // Opaque write, then one off screen that must change nothing.
        send_command(make_cmd(REQ_WRITE_OPAQUE, 5, 7, 0, 0, 8'hFF, 8'h00, 8'h80, 8'hFF));
        send_command(make_cmd(REQ_READ, 5, 7, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_WRITE_OPAQUE, COORD_MAX, 3, 0, 0,
                              8'hAA, 8'hBB, 8'hCC, 8'hDD));
        send_command(make_cmd(REQ_READ, 255, 3, 0, 0, 0, 0, 0, 0));
        // Blends with zero alpha (skipped), full alpha (plain write) and half alpha.
        send_command(make_cmd(REQ_WRITE_BLEND, 5, 7, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_cmd(REQ_READ, 5, 7, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_WRITE_BLEND, 5, 7, 0, 0, 8'h12, 8'h34, 8'h56, 8'hFF));
        send_command(make_cmd(REQ_READ, 5, 7, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_WRITE_BLEND, 5, 7, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h80));
        send_command(make_cmd(REQ_READ, 5, 7, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_WRITE_BLEND, 300, 2, 0, 0, 8'h01, 8'h02, 8'h03, 8'd77));
        // Empty rectangles, then one hanging over the bottom-right corner.
        send_command(make_cmd(REQ_FILL_OPAQUE, 10, 10, 0, 5, 8'h01, 8'h01, 8'h01, 8'h01));
        send_command(make_cmd(REQ_FILL_OPAQUE, 10, 10, 5, 0, 8'h01, 8'h01, 8'h01, 8'h01));
        send_command(make_cmd(REQ_FILL_OPAQUE, 250, 250, 20, 20,
                              8'hFF, 8'hFE, 8'hFD, 8'hFC));
        send_command(make_cmd(REQ_READ, 255, 255, 0, 0, 0, 0, 0, 0));
        // Blended fills at the lowest, zero and full alpha.
        send_command(make_cmd(REQ_FILL_BLEND, 0, 0, 3, 2, 8'hFF, 8'hFF, 8'hFF, 8'h01));
        send_command(make_cmd(REQ_READ, 2, 1, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(REQ_FILL_BLEND, 0, 0, 4, 4, 8'h77, 8'h77, 8'h77, 8'h00));
        send_command(make_cmd(REQ_FILL_BLEND, 1, 1, 2, 2, 8'h9A, 8'hBC, 8'hDE, 8'hFF));
        send_command(make_cmd(REQ_READ, 1, 1, 0, 0, 0, 0, 0, 0));
        // Unknown codes with every other field at its maximum.
        for (int code = REQ_UNKNOWN_FIRST; code <= REQ_UNKNOWN_LAST; code++) begin
            send_command(make_cmd(REQ_W'(code), COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX));
        end
    endtask

    // Result side: a beat is taken at an edge where valid is high and our stall was
    // low. The stall for the next edge is either part of a counted hold-off or a
    // random choice at the current idle odds.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && !rsp_stall) begin
                sb.check_result(rsp_beat);
            end
            if (rsp_hold_cycles > 0) begin
                rsp_stall <= 1'b1;
                rsp_hold_cycles--;
            end else begin
                rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // Main sequence: reset, the directed opening, then the random phases. The
    // first third idles mostly on the result side, the second mostly on the
    // command side, the last third runs flat out.
    initial begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_screen_config(256, 256, 1'b0);
        run_directed();

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            apply_screen_config(phase_width[phase], phase_height[phase],
                                phase_rgb[phase] != 0);
            if (phase < PHASES / 3) begin
                send_idle_pct = 36;
                rcv_idle_pct  = 59;
            end else if (phase < 2 * PHASES / 3) begin
                send_idle_pct = 59;
                rcv_idle_pct  = 36;
            end else begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
                // Partway through one phase the result side freezes for a long
                // stretch while commands keep coming, so the engine backs up and
                // has to stall its command input.
                if (phase == 5 && item == 40) rsp_hold_cycles = 300;
                send_command(random_command());
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);

        $display("Ran %0d commands over %0d screen settings: %0d reads (%0d on screen),",
                 n_reads + n_writes + n_fills + n_unknown, PHASES + 1, n_reads,
                 sb.read_hits);
        $display("  %0d single-pixel writes, %0d rectangle fills, %0d unknown codes.",
                 n_writes, n_fills, n_unknown);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Safety net in case the engine stops answering.
    initial begin
        #60_000_000;
        $display("Timeout: %0d results still outstanding", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
